// ----- src/bdq_pkg.sv -----
package bdq_pkg;

    // Default sizing of the list.
    localparam int DEPTH_DEF  = 16;
    localparam int DATA_W_DEF = 32;

    // Fixed widths of the item fields.
    localparam int REQ_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 8;
    localparam int POS_W    = 5;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CLEAR      = 3'd4;
    localparam logic [REQ_W-1:0] REQ_READ       = 3'd5;
    localparam logic [REQ_W-1:0] REQ_FIND       = 3'd6;

    // Status codes.
    localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STS_POP_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STS_PUSH_FULL = 2'd2;

    // Position reported when a find has no match.
    localparam logic [POS_W-1:0] POS_NONE = '1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;    // latch the incoming item
        logic exec;      // carry out the latched request
        logic capture;   // take the read data as the result value
        logic scan;      // compare one entry of a find
        logic load_out;  // move the result into the output register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_read;  // the request reads one entry
        logic need_scan;  // a find with at least one entry to compare
        logic scan_done;  // the entry under compare ends the find
    } t_dp_sts;

endpackage

// ----- src/bounded_deque_with_search.sv -----
// Bounded deque with search: an ordered list of up to DEPTH signed values kept in a
// ring memory with a head pointer and a fill count. Each item is a request to push at
// the front or back, pop from the front or back, clear, read the entry at an index,
// or find the first position holding a value; each gives exactly one result item that
// carries the count and an empty flag after the request. The block works on one item
// at a time: each item is accepted and executed; a successful pop or read then captures
// the entry read, and a find scans entries (1 to DEPTH compared, or none on an empty
// list) before the result is loaded into the output register once that is free. The
// find scan walks the single read port of the entry memory one entry per cycle from
// the front. A finished result waits in the output register while the next item is
// taken.
module bounded_deque_with_search #(
    parameter int DEPTH      = bdq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = bdq_pkg::DATA_W_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [bdq_pkg::REQ_W-1:0]            i_req_type,
    input  logic signed [bdq_pkg::VALUE_W-1:0]   i_value,
    input  logic [bdq_pkg::INDEX_W-1:0]          i_index,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [bdq_pkg::VALUE_W-1:0]   o_data,
    output logic                                 o_found,
    output logic signed [bdq_pkg::POS_W-1:0]     o_position,
    output logic [bdq_pkg::COUNT_W-1:0]          o_entry_count,
    output logic                                 o_empty_res,
    output logic [bdq_pkg::STATUS_W-1:0]         o_status
);
    import bdq_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Sequencing of each item.
    bdq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Ring storage, pointers and result registers.
    bdq_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_req_type    (i_req_type),
        .i_value       (i_value),
        .i_index       (i_index),
        .o_data        (o_data),
        .o_found       (o_found),
        .o_position    (o_position),
        .o_entry_count (o_entry_count),
        .o_empty_res   (o_empty_res),
        .o_status      (o_status)
    );

endmodule

// ----- src/bdq_ctrl.sv -----
module bdq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    output logic              o_valid,
    input  logic              i_stall,
    input  bdq_pkg::t_dp_sts  i_sts,
    output bdq_pkg::t_dp_cmd  o_cmd
);
    import bdq_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_RDATA = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_RES   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       out_free;

    // The output register can take a new result when empty or being drained.
    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_out_valid;

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                priority if (i_sts.need_read) begin
                    n_state = S_RDATA;
                end else if (i_sts.need_scan) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_RES;
                end
            end
            S_RDATA: begin
                o_cmd.capture = 1'b1;
                n_state       = S_RES;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_RES;
                end
            end
            S_RES: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and output valid registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // A result never overwrites one that is still held by the receiver.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.load_out && r_out_valid && i_stall))
        else $error("result loaded over a stalled result");

    // An accepted item is always executed in the following cycle.
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> (r_state == S_EXEC))
        else $error("accepted item not executed");

    // Every result load returns the block to taking items.
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |=> (r_state == S_IDLE && r_out_valid))
        else $error("result load did not complete the item");

endmodule

// ----- src/bdq_dp.sv -----
module bdq_dp #(
    parameter int DEPTH      = bdq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = bdq_pkg::DATA_W_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  bdq_pkg::t_dp_cmd                     i_cmd,
    output bdq_pkg::t_dp_sts                     o_sts,
    input  logic [bdq_pkg::REQ_W-1:0]            i_req_type,
    input  logic signed [bdq_pkg::VALUE_W-1:0]   i_value,
    input  logic [bdq_pkg::INDEX_W-1:0]          i_index,
    output logic signed [bdq_pkg::VALUE_W-1:0]   o_data,
    output logic                                 o_found,
    output logic signed [bdq_pkg::POS_W-1:0]     o_position,
    output logic [bdq_pkg::COUNT_W-1:0]          o_entry_count,
    output logic                                 o_empty_res,
    output logic [bdq_pkg::STATUS_W-1:0]         o_status
);
    import bdq_pkg::*;

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
    localparam logic [ADDR_W:0]   RING_SIZE = (ADDR_W + 1)'(DEPTH);
    localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(DEPTH);

    // Entry storage, one write and one registered read per cycle.
    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_data;

    // Pointers and the latched request.
    logic [ADDR_W-1:0]     r_head;
    logic [ADDR_W-1:0]     n_head;
    logic [CNT_W-1:0]      r_fill;
    logic [CNT_W-1:0]      n_fill;
    logic [REQ_W-1:0]      r_req;
    logic [DATA_WIDTH-1:0] r_val;
    logic [INDEX_W-1:0]    r_idx;
    logic [ADDR_W-1:0]     r_scan;
    logic [ADDR_W-1:0]     n_scan;

    // Working result.
    logic [VALUE_W-1:0]    r_data;
    logic [VALUE_W-1:0]    n_data;
    logic                  r_found;
    logic                  n_found;
    logic [POS_W-1:0]      r_pos;
    logic [POS_W-1:0]      n_pos;
    logic [STATUS_W-1:0]   r_status;
    logic [STATUS_W-1:0]   n_status;

    // Output register.
    logic [VALUE_W-1:0]    r_o_data;
    logic                  r_o_found;
    logic [POS_W-1:0]      r_o_pos;
    logic [COUNT_W-1:0]    r_o_count;
    logic                  r_o_empty;
    logic [STATUS_W-1:0]   r_o_status;

    // Memory port controls.
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic                  rd_en;
    logic [ADDR_W-1:0]     rd_addr;

    logic signed [63:0]           val_wide;
    logic signed [DATA_WIDTH-1:0] rd_signed;
    logic signed [63:0]           rd_wide;
    logic                         is_empty;
    logic                         is_full;
    logic                         idx_in_range;
    logic                         scan_match;
    logic                         scan_last;

    // Ring position of base plus an offset below the depth.
    function automatic logic [ADDR_W-1:0] ring_add(
        input logic [ADDR_W-1:0] base,
        input logic [ADDR_W-1:0] off
    );
        logic [ADDR_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= RING_SIZE) begin
            sum = sum - RING_SIZE;
        end
        return sum[ADDR_W-1:0];
    endfunction

    // Value conversions between the item width and the stored width.
    assign val_wide  = 64'(i_value);
    assign rd_signed = r_rd_data;
    assign rd_wide   = 64'(rd_signed);

    assign is_empty     = (r_fill == '0);
    assign is_full      = (r_fill >= FULL_CNT);
    assign idx_in_range = (CMP_W'(r_idx) < CMP_W'(r_fill));
    assign scan_match   = (r_rd_data == r_val);
    assign scan_last    = ((CNT_W'(r_scan) + CNT_W'(1)) == r_fill);

    // Status to the controller.
    always_comb begin
        o_sts.need_read = 1'b0;
        o_sts.need_scan = 1'b0;
        unique case (r_req)
            REQ_POP_FRONT, REQ_POP_BACK: o_sts.need_read = !is_empty;
            REQ_READ:                    o_sts.need_read = idx_in_range;
            REQ_FIND:                    o_sts.need_scan = !is_empty;
            default: begin
            end
        endcase
        o_sts.scan_done = scan_match || scan_last;
    end

    // Request execution, entry reads and the find scan.
    always_comb begin
        n_head   = r_head;
        n_fill   = r_fill;
        n_scan   = r_scan;
        n_data   = r_data;
        n_found  = r_found;
        n_pos    = r_pos;
        n_status = r_status;
        wr_en    = 1'b0;
        wr_addr  = r_head;
        rd_en    = 1'b0;
        rd_addr  = r_head;

        if (i_cmd.exec) begin
            n_data   = '0;
            n_found  = 1'b0;
            n_pos    = POS_NONE;
            n_status = STS_OK;
            n_scan   = '0;
            unique case (r_req)
                REQ_PUSH_FRONT: begin
                    if (is_full) begin
                        n_status = STS_PUSH_FULL;
                    end else begin
                        n_head  = (r_head == '0) ? LAST_SLOT : r_head - ADDR_W'(1);
                        wr_en   = 1'b1;
                        wr_addr = n_head;
                        n_fill  = r_fill + CNT_W'(1);
                    end
                end
                REQ_PUSH_BACK: begin
                    if (is_full) begin
                        n_status = STS_PUSH_FULL;
                    end else begin
                        wr_en   = 1'b1;
                        wr_addr = ring_add(r_head, ADDR_W'(r_fill));
                        n_fill  = r_fill + CNT_W'(1);
                    end
                end
                REQ_POP_FRONT: begin
                    if (is_empty) begin
                        n_status = STS_POP_EMPTY;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = r_head;
                        n_head  = ring_add(r_head, ADDR_W'(1));
                        n_fill  = r_fill - CNT_W'(1);
                    end
                end
                REQ_POP_BACK: begin
                    if (is_empty) begin
                        n_status = STS_POP_EMPTY;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = ring_add(r_head, ADDR_W'(r_fill - CNT_W'(1)));
                        n_fill  = r_fill - CNT_W'(1);
                    end
                end
                REQ_CLEAR: begin
                    n_head = '0;
                    n_fill = '0;
                end
                REQ_READ: begin
                    if (idx_in_range) begin
                        n_found = 1'b1;
                        rd_en   = 1'b1;
                        rd_addr = ring_add(r_head, ADDR_W'(r_idx));
                    end
                end
                REQ_FIND: begin
                    rd_en   = !is_empty;
                    rd_addr = r_head;
                end
                default: begin
                end
            endcase
        end

        // A popped or read entry becomes the result value.
        if (i_cmd.capture) begin
            n_data = rd_wide[VALUE_W-1:0];
        end

        // One entry of a find is compared per cycle.
        if (i_cmd.scan) begin
            priority if (scan_match) begin
                n_found = 1'b1;
                n_pos   = POS_W'(r_scan);
            end else if (!scan_last) begin
                n_scan  = r_scan + ADDR_W'(1);
                rd_en   = 1'b1;
                rd_addr = ring_add(r_head, n_scan);
            end
        end
    end

    // Entry memory.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= r_val;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Head and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_fill <= '0;
        end else begin
            r_head <= n_head;
            r_fill <= n_fill;
        end
    end

    // Latched request, scan position and working result.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req <= i_req_type;
            r_val <= val_wide[DATA_WIDTH-1:0];
            r_idx <= i_index;
        end
        r_scan   <= n_scan;
        r_data   <= n_data;
        r_found  <= n_found;
        r_pos    <= n_pos;
        r_status <= n_status;
    end

    // Output register, loaded once per item.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_data   <= r_data;
            r_o_found  <= r_found;
            r_o_pos    <= r_pos;
            r_o_count  <= COUNT_W'(r_fill);
            r_o_empty  <= is_empty;
            r_o_status <= r_status;
        end
    end

    assign o_data        = r_o_data;
    assign o_found       = r_o_found;
    assign o_position    = r_o_pos;
    assign o_entry_count = r_o_count;
    assign o_empty_res   = r_o_empty;
    assign o_status      = r_o_status;

    // The fill count never goes past the capacity.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FULL_CNT)
        else $error("fill count beyond capacity");

    // The head always points into the ring.
    a_head_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= LAST_SLOT)
        else $error("head pointer outside the ring");

    // A clear leaves an empty list with the head at the start.
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && r_req == REQ_CLEAR) |=> (r_fill == '0 && r_head == '0))
        else $error("clear did not empty the list");

    // Pointers move only while a request executes.
    a_ptr_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.exec |=> ($stable(r_fill) && $stable(r_head)))
        else $error("pointers changed outside execution");

endmodule

// ----- dv/tb_top.sv -----
module tb_top;
    import bdq_pkg::*;

    localparam int LIST_DEPTH = DEPTH_DEF;

    // Code 7 is not a request; the block answers it as a no-op.
    localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY} t_stall_mode;

    // One result item, packed in port order.
    typedef struct packed {
        logic signed [VALUE_W-1:0] data;
        logic                      found;
        logic signed [POS_W-1:0]   position;
        logic [COUNT_W-1:0]        entry_count;
        logic                      empty_res;
        logic [STATUS_W-1:0]       status;
    } t_deque_result;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic                       o_stall;
    logic [REQ_W-1:0]           i_req_type = '0;
    logic signed [VALUE_W-1:0]  i_value = '0;
    logic [INDEX_W-1:0]         i_index = '0;
    logic                       o_valid;
    logic                       i_stall = 1'b0;
    logic signed [VALUE_W-1:0]  o_data;
    logic                       o_found;
    logic signed [POS_W-1:0]    o_position;
    logic [COUNT_W-1:0]         o_entry_count;
    logic                       o_empty_res;
    logic [STATUS_W-1:0]        o_status;

    bounded_deque_with_search dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_req_type    (i_req_type),
        .i_value       (i_value),
        .i_index       (i_index),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_data        (o_data),
        .o_found       (o_found),
        .o_position    (o_position),
        .o_entry_count (o_entry_count),
        .o_empty_res   (o_empty_res),
        .o_status      (o_status)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the list, updated as each item is accepted.
    logic signed [VALUE_W-1:0] ring_mem [LIST_DEPTH];
    logic [3:0]                ring_head = '0;
    logic [COUNT_W-1:0]        ring_fill = '0;

    t_deque_result expected_results [$];
    int error_count    = 0;
    int request_count  = 0;
    int find_hits      = 0;
    int full_pushes    = 0;
    int empty_pops     = 0;

    // Sender burst control and receiver stall pattern.
    int          burst_left = 0;
    int          gap_max    = 8;
    t_stall_mode stall_mode = STALL_NONE;
    int          stall_hold = 0;
    logic        stall_level = 1'b0;

    // Values used to make finds hit and to create duplicates.
    logic signed [VALUE_W-1:0] value_pool [8] = '{
        32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0000, 32'shFFFF_FFFF,
        32'sh0000_0001, 32'sh0000_0005, 32'sh5555_5555, 32'shAAAA_AAAA
    };
    logic signed [VALUE_W-1:0] recent_values [16];
    logic [3:0]                recent_wr = '0;

    initial begin
        foreach (recent_values[k]) recent_values[k] = '0;
    end

    // Apply one request to the shadow list and work out its result.
    task automatic apply_request(input logic [REQ_W-1:0] req,
                                 input logic signed [VALUE_W-1:0] val,
                                 input logic [INDEX_W-1:0] idx,
                                 output t_deque_result res);
        int k;
        res = '0;
        res.position = POS_NONE;
        res.status = STS_OK;
        case (req)
            REQ_PUSH_FRONT: begin
                if (ring_fill == LIST_DEPTH) begin
                    res.status = STS_PUSH_FULL;
                end else begin
                    ring_head = ring_head - 4'd1;
                    ring_mem[ring_head] = val;
                    ring_fill = ring_fill + 1'b1;
                end
            end
            REQ_PUSH_BACK: begin
                if (ring_fill == LIST_DEPTH) begin
                    res.status = STS_PUSH_FULL;
                end else begin
                    ring_mem[4'(ring_head + ring_fill)] = val;
                    ring_fill = ring_fill + 1'b1;
                end
            end
            REQ_POP_FRONT: begin
                if (ring_fill == 0) begin
                    res.status = STS_POP_EMPTY;
                end else begin
                    res.data = ring_mem[ring_head];
                    ring_head = ring_head + 4'd1;
                    ring_fill = ring_fill - 1'b1;
                end
            end
            REQ_POP_BACK: begin
                if (ring_fill == 0) begin
                    res.status = STS_POP_EMPTY;
                end else begin
                    res.data = ring_mem[4'(ring_head + ring_fill - 1)];
                    ring_fill = ring_fill - 1'b1;
                end
            end
            REQ_CLEAR: begin
                ring_head = '0;
                ring_fill = '0;
            end
            REQ_READ: begin
                if (idx < ring_fill) begin
                    res.found = 1'b1;
                    res.data = ring_mem[4'(ring_head + idx)];
                end
            end
            REQ_FIND: begin
                for (k = 0; k < ring_fill; k++) begin
                    if (!res.found && ring_mem[4'(ring_head + k)] == val) begin
                        res.found = 1'b1;
                        res.position = POS_W'(k);
                    end
                end
            end
            default: begin
            end
        endcase
        res.entry_count = ring_fill;
        res.empty_res = (ring_fill == 0);
    endtask

    // Check each result leaving the block, then record each accepted item.
    always @(posedge i_clk) begin : result_check
        t_deque_result actual;
        t_deque_result predicted;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                actual = {o_data, o_found, o_position, o_entry_count, o_empty_res, o_status};
                if (expected_results.size() == 0) begin
                    error_count++;
                    $display("%0t: result with nothing expected: data=%0d found=%0d pos=%0d",
                             $time, actual.data, actual.found, actual.position);
                end else begin
                    predicted = expected_results.pop_front();
                    if (actual !== predicted) begin
                        error_count++;
                        $display({"%0t: mismatch expected data=%0d found=%0d pos=%0d",
                                  " cnt=%0d empty=%0d sts=%0d"},
                                 $time, predicted.data, predicted.found, predicted.position,
                                 predicted.entry_count, predicted.empty_res, predicted.status);
                        $display({"%0t:          actual data=%0d found=%0d pos=%0d",
                                  " cnt=%0d empty=%0d sts=%0d"},
                                 $time, actual.data, actual.found, actual.position,
                                 actual.entry_count, actual.empty_res, actual.status);
                    end
                end
            end
            if (i_valid && !o_stall) begin
                apply_request(i_req_type, i_value, i_index, predicted);
                expected_results.push_back(predicted);
                request_count++;
                if (i_req_type == REQ_FIND && predicted.found) find_hits++;
                if (predicted.status == STS_PUSH_FULL) full_pushes++;
                if (predicted.status == STS_POP_EMPTY) empty_pops++;
            end
        end
    end

    // Receiver stall pattern: runs of stall and ready whose lengths depend on the mode.
    always @(posedge i_clk) begin
        if (stall_hold <= 0) begin
            case (stall_mode)
                STALL_NONE: begin
                    stall_level = 1'b0;
                    stall_hold = 1;
                end
                STALL_LIGHT: begin
                    stall_level = ($urandom_range(0, 3) == 0);
                    stall_hold = $urandom_range(1, 3);
                end
                default: begin
                    stall_level = $urandom_range(0, 1);
                    stall_hold = stall_level ? $urandom_range(1, 24) : $urandom_range(1, 8);
                end
            endcase
        end
        stall_hold--;
        i_stall <= i_rst_n ? stall_level : 1'b0;
    end

    // Send one item; the sender may idle between bursts of random length.
    task automatic send_item(input logic [REQ_W-1:0] req,
                             input logic signed [VALUE_W-1:0] val,
                             input logic [INDEX_W-1:0] idx);
        int gap;
        if (burst_left <= 0) begin
            gap = (gap_max == 0 || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, gap_max);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        i_valid    <= 1'b1;
        i_req_type <= req;
        i_value    <= val;
        i_index    <= idx;
        if (req == REQ_PUSH_FRONT || req == REQ_PUSH_BACK) begin
            recent_values[recent_wr] = val;
            recent_wr++;
        end
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        burst_left--;
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 3) return value_pool[$urandom_range(0, 7)];
        if (sel < 6) return recent_values[$urandom_range(0, 15)];
        return $urandom;
    endfunction

    function automatic logic [REQ_W-1:0] pick_push();
        return $urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
    endfunction

    function automatic logic [REQ_W-1:0] pick_pop();
        return $urandom_range(0, 1) ? REQ_POP_BACK : REQ_POP_FRONT;
    endfunction

    // Requests on a list that has never held anything.
    task automatic test_empty_list();
        send_item(REQ_POP_FRONT, 32'sd0, 8'd0);
        send_item(REQ_POP_BACK, 32'sd0, 8'd0);
        send_item(REQ_READ, 32'sd0, 8'd0);
        send_item(REQ_FIND, 32'sd0, 8'd0);
    endtask

    // Every operation at least once, with the extreme values and indexes.
    task automatic test_directed_ops();
        send_item(REQ_PUSH_BACK, 32'sh7FFF_FFFF, 8'd0);
        send_item(REQ_PUSH_FRONT, 32'sh8000_0000, 8'd0);
        send_item(REQ_PUSH_BACK, 32'shFFFF_FFFF, 8'd0);
        send_item(REQ_PUSH_FRONT, 32'sh0000_0000, 8'hFF);
        send_item(REQ_READ, 32'sd0, 8'd0);
        send_item(REQ_READ, 32'sd0, 8'd3);
        send_item(REQ_READ, 32'sd0, 8'd4);
        send_item(REQ_READ, 32'shFFFF_FFFF, 8'hFF);
        send_item(REQ_FIND, 32'shFFFF_FFFF, 8'd0);
        send_item(REQ_FIND, 32'sd12345, 8'd0);
        send_item(REQ_FIND, 32'sh8000_0000, 8'd0);
        send_item(REQ_POP_FRONT, 32'sd0, 8'd0);
        send_item(REQ_POP_BACK, 32'sd0, 8'd0);
        send_item(REQ_POP_BACK, 32'sd0, 8'd0);
        // The last entry leaves by the back and must still be returned.
        send_item(REQ_POP_BACK, 32'sd0, 8'd0);
        send_item(REQ_PUSH_FRONT, 32'sd7, 8'd0);
        send_item(REQ_CLEAR, 32'sd0, 8'd0);
        send_item(REQ_UNUSED, 32'shFFFF_FFFF, 8'hFF);
        send_item(REQ_READ, 32'sd0, 8'd0);
    endtask

    // Fill the list to capacity, push past it, search it, then drain past empty.
    task automatic test_fill_and_overflow(input int rounds);
        int r;
        int k;
        for (r = 0; r < rounds; r++) begin
            stall_mode = t_stall_mode'(r % 3);
            gap_max = (r % 2) ? 0 : 10;
            send_item(REQ_CLEAR, $urandom, 8'($urandom));
            for (k = 0; k < LIST_DEPTH; k++) send_item(pick_push(), pick_value(), 8'($urandom));
            repeat ($urandom_range(1, 3)) send_item(pick_push(), $urandom, 8'd0);
            repeat (4) send_item(REQ_FIND, pick_value(), 8'd0);
            send_item(REQ_FIND, recent_values[4'(recent_wr - 1)], 8'd0);
            send_item(REQ_READ, 32'sd0, 8'(LIST_DEPTH - 1));
            send_item(REQ_READ, 32'sd0, 8'(LIST_DEPTH));
            send_item(REQ_READ, 32'sd0, 8'($urandom_range(0, 255)));
            for (k = 0; k < LIST_DEPTH; k++) begin
                send_item(pick_pop(), $urandom, 8'($urandom));
                if ($urandom_range(0, 3) == 0) send_item(REQ_FIND, pick_value(), 8'd0);
            end
            repeat ($urandom_range(1, 2)) send_item(pick_pop(), $urandom, 8'd0);
        end
    endtask

    // Long random mix; phases lean toward filling or draining the list.
    task automatic test_random_mix(input int phases, input int per_phase);
        int p;
        int n;
        int roll;
        int push_pct;
        int pop_pct;
        logic [REQ_W-1:0]   req;
        logic [INDEX_W-1:0] idx;
        for (p = 0; p < phases; p++) begin
            stall_mode = t_stall_mode'($urandom_range(0, 2));
            gap_max = (p % 4 == 3) ? 0 : $urandom_range(2, 12);
            push_pct = (p % 2 == 0) ? 48 : 18;
            pop_pct  = (p % 2 == 0) ? 14 : 40;
            for (n = 0; n < per_phase; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < push_pct) req = pick_push();
                else if (roll < push_pct + pop_pct) req = pick_pop();
                else if (roll < push_pct + pop_pct + 16) req = REQ_READ;
                else if (roll < 96) req = REQ_FIND;
                else if (roll < 98) req = REQ_CLEAR;
                else req = REQ_UNUSED;
                idx = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                  : 8'($urandom_range(0, LIST_DEPTH + 1));
                send_item(req, pick_value(), idx);
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_list();
        test_directed_ops();
        test_fill_and_overflow(6);
        test_random_mix(14, 100);

        // Drain the outstanding results.
        i_valid <= 1'b0;
        stall_mode = STALL_LIGHT;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            error_count += expected_results.size();
            $display("%0t: %0d expected results never arrived", $time, expected_results.size());
        end

        $display("Ran %0d requests: %0d find hits, %0d pushes on a full list, %0d pops on empty.",
                 request_count, find_hits, full_pushes, empty_pops);
        $display("Sender bursts and receiver stall patterns varied across phases; %0d errors.",
                 error_count);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
